// File: src/cell_list_link_update_assert.svh
// Assertion macros shared by the link update RTL.
// Each check is sampled on the rising edge of clk.
`ifndef CELL_LIST_LINK_UPDATE_ASSERT_SVH
`define CELL_LIST_LINK_UPDATE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that is switched off while rst_n is low
`define CLLU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that also holds through reset
`define CLLU_CHECK_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`else

`define CLLU_CHECK(lbl, prop, msg)
`define CLLU_CHECK_ANY(lbl, prop, msg)

`endif

`endif

// File: src/cllu_pkg.sv
`timescale 1ns / 1ps

package cllu_pkg;

  // Fixed field widths
  localparam int PART_W    = 10;
  localparam int BOX_W     = 5;
  localparam int HEAD_W    = 11;
  localparam int PART_SPAN = 1024;

  // Link or head value for "no particle"
  localparam logic [HEAD_W-1:0] NONE = 11'h7FF;

  // Command codes
  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // Microprogram steps
  typedef enum logic [2:0] {
    S_CLEAR,
    S_WAIT,
    S_EXEC,
    S_LINK,
    S_EMIT
  } step_t;

  // Branch and hold conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_CLR_BUSY,
    C_IS_REMOVE,
    C_OUT_BUSY
  } cond_t;

  // Memory write groups
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_PRIMARY,
    WR_LINK
  } wr_t;

  // One control word
  typedef struct packed {
    logic  accept;
    wr_t   wr;
    logic  emit;
    cond_t stay;
    cond_t jmp;
    step_t target;
  } uop_t;

  // Status from the datapath
  typedef struct packed {
    logic clr_busy;
    logic is_remove;
  } dp_stat_t;

  // Status seen by the sequencer
  typedef struct packed {
    logic     in_fire;
    logic     out_busy;
    dp_stat_t dp;
  } stat_t;

endpackage

// File: src/cllu_seq.sv
`timescale 1ns / 1ps
`include "cell_list_link_update_assert.svh"

module cllu_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  cllu_pkg::stat_t stat,
  output cllu_pkg::uop_t  ctl
);

  cllu_pkg::step_t step_r, step_nxt;
  logic            stay_hit, jmp_hit;

  function automatic logic cond_hit(cllu_pkg::cond_t c, cllu_pkg::stat_t s);
    logic hit;
    case (c)
      cllu_pkg::C_NEVER:     hit = 1'b0;
      cllu_pkg::C_ALWAYS:    hit = 1'b1;
      cllu_pkg::C_NO_ITEM:   hit = !s.in_fire;
      cllu_pkg::C_CLR_BUSY:  hit = s.dp.clr_busy;
      cllu_pkg::C_IS_REMOVE: hit = s.dp.is_remove;
      cllu_pkg::C_OUT_BUSY:  hit = s.out_busy;
      default:               hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Microcode ROM: accept, write group, emit, hold, jump, target
  always_comb begin
    case (step_r)
      cllu_pkg::S_CLEAR: ctl = '{1'b0, cllu_pkg::WR_CLEAR, 1'b0,
                                 cllu_pkg::C_CLR_BUSY, cllu_pkg::C_NEVER, cllu_pkg::S_CLEAR};
      cllu_pkg::S_WAIT:  ctl = '{1'b1, cllu_pkg::WR_NONE, 1'b0,
                                 cllu_pkg::C_NO_ITEM, cllu_pkg::C_NEVER, cllu_pkg::S_WAIT};
      cllu_pkg::S_EXEC:  ctl = '{1'b0, cllu_pkg::WR_PRIMARY, 1'b0,
                                 cllu_pkg::C_NEVER, cllu_pkg::C_IS_REMOVE, cllu_pkg::S_EMIT};
      cllu_pkg::S_LINK:  ctl = '{1'b0, cllu_pkg::WR_LINK, 1'b0,
                                 cllu_pkg::C_NEVER, cllu_pkg::C_NEVER, cllu_pkg::S_EMIT};
      cllu_pkg::S_EMIT:  ctl = '{1'b0, cllu_pkg::WR_NONE, 1'b1,
                                 cllu_pkg::C_OUT_BUSY, cllu_pkg::C_ALWAYS, cllu_pkg::S_WAIT};
      default:           ctl = '{1'b0, cllu_pkg::WR_NONE, 1'b0,
                                 cllu_pkg::C_NEVER, cllu_pkg::C_ALWAYS, cllu_pkg::S_WAIT};
    endcase
  end

  // Step counter: hold, jump or advance
  always_comb begin
    stay_hit = cond_hit(ctl.stay, stat);
    jmp_hit  = cond_hit(ctl.jmp, stat);
    if (stay_hit) begin
      step_nxt = step_r;
    end else if (jmp_hit) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = cllu_pkg::step_t'(step_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= cllu_pkg::S_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

  `CLLU_CHECK(a_fire_to_exec, stat.in_fire |=> step_r == cllu_pkg::S_EXEC, "accept did not start execution")
  `CLLU_CHECK(a_link_only_add, step_r == cllu_pkg::S_LINK |-> !stat.dp.is_remove, "link step on a remove")
  `CLLU_CHECK(a_emit_leaves, (step_r == cllu_pkg::S_EMIT) && !stat.out_busy |=> step_r == cllu_pkg::S_WAIT, "emit step did not release")

endmodule

// File: src/cllu_dp.sv
`timescale 1ns / 1ps
`include "cell_list_link_update_assert.svh"

module cllu_dp #(
  parameter int BOXES_X   = 32,
  parameter int BOXES_Y   = 32,
  parameter int PARTICLES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cllu_pkg::uop_t                ctl,
  input  logic                          in_fire,
  input  logic                          in_command,
  input  logic [cllu_pkg::PART_W-1:0]   in_particle,
  input  logic [cllu_pkg::BOX_W-1:0]    in_box_x,
  input  logic [cllu_pkg::BOX_W-1:0]    in_box_y,
  output cllu_pkg::dp_stat_t            dstat,
  output logic [cllu_pkg::HEAD_W-1:0]   old_head,
  output logic [cllu_pkg::HEAD_W-1:0]   new_head
);

  localparam int NBOXES = BOXES_X * BOXES_Y;
  localparam int BIW    = (NBOXES > 1) ? $clog2(NBOXES) : 1;
  localparam int LDEPTH = (PARTICLES < cllu_pkg::PART_SPAN) ? PARTICLES : cllu_pkg::PART_SPAN;
  localparam int LIW    = $clog2(LDEPTH);
  localparam logic [BIW-1:0] LAST_BOX = BIW'(NBOXES - 1);

  // Memories
  logic [cllu_pkg::HEAD_W-1:0] head_mem [NBOXES];
  logic [cllu_pkg::HEAD_W-1:0] prev_mem [LDEPTH];
  logic [cllu_pkg::HEAD_W-1:0] next_mem [LDEPTH];

  logic [cllu_pkg::HEAD_W-1:0] head_rd_r, prev_rd_r, next_rd_r;

  // Item registers
  cllu_pkg::cmd_t              cmd_r;
  logic [cllu_pkg::PART_W-1:0] part_r;
  logic [BIW-1:0]              box_r;
  logic                        box_ok_r, part_ok_r;
  logic [cllu_pkg::HEAD_W-1:0] oh_r, nh_r;

  // Clearing pass
  logic           clr_busy_r;
  logic [BIW-1:0] clr_cnt_r;

  logic [BIW-1:0]              rd_box;
  logic                        box_ok, part_ok, run, is_head;
  logic [cllu_pkg::HEAD_W-1:0] p_val, oh, nh, nx, pv;

  logic                        head_we, prev_we, next_we;
  logic [BIW-1:0]              head_wa;
  logic [LIW-1:0]              prev_wa, next_wa;
  logic [cllu_pkg::HEAD_W-1:0] head_wd, prev_wd, next_wd;

  function automatic logic is_part(logic [cllu_pkg::HEAD_W-1:0] v);
    return !v[cllu_pkg::HEAD_W-1] && (int'(v[cllu_pkg::PART_W-1:0]) < PARTICLES);
  endfunction

  // Input decode
  assign rd_box  = BIW'(int'(in_box_y) * BOXES_X + int'(in_box_x));
  assign box_ok  = (int'(in_box_x) < BOXES_X) && (int'(in_box_y) < BOXES_Y);
  assign part_ok = int'(in_particle) < PARTICLES;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= cllu_pkg::cmd_t'(in_command);
      part_r    <= in_particle;
      box_r     <= rd_box;
      box_ok_r  <= box_ok;
      part_ok_r <= part_ok;
    end
  end

  // Values seen in the execute step
  assign p_val   = {1'b0, part_r};
  assign run     = box_ok_r && part_ok_r;
  assign oh      = box_ok_r ? head_rd_r : cllu_pkg::NONE;
  assign nx      = next_rd_r;
  assign pv      = prev_rd_r;
  assign is_head = head_rd_r == p_val;

  always_comb begin
    if (!box_ok_r) begin
      nh = cllu_pkg::NONE;
    end else if (!part_ok_r) begin
      nh = oh;
    end else if (cmd_r == cllu_pkg::CMD_ADD) begin
      nh = p_val;
    end else if (is_head) begin
      nh = nx;
    end else begin
      nh = oh;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr == cllu_pkg::WR_PRIMARY) begin
      oh_r <= oh;
      nh_r <= nh;
    end
  end

  // Write port selection
  always_comb begin
    head_we = 1'b0;
    head_wa = box_r;
    head_wd = cllu_pkg::NONE;
    prev_we = 1'b0;
    prev_wa = part_r[LIW-1:0];
    prev_wd = cllu_pkg::NONE;
    next_we = 1'b0;
    next_wa = part_r[LIW-1:0];
    next_wd = nx;
    case (ctl.wr)
      cllu_pkg::WR_CLEAR: begin
        head_we = clr_busy_r;
        head_wa = clr_cnt_r;
      end
      cllu_pkg::WR_PRIMARY: begin
        if (run && cmd_r == cllu_pkg::CMD_ADD) begin
          // add: particle becomes head, old head follows it
          head_we = 1'b1;
          head_wd = p_val;
          prev_we = 1'b1;
          next_we = 1'b1;
          next_wd = oh;
        end else if (run && is_head) begin
          // remove head: next takes over
          head_we = 1'b1;
          head_wd = nx;
          prev_we = is_part(nx);
          prev_wa = nx[LIW-1:0];
        end else if (run) begin
          // remove inside the list: join neighbors
          next_we = is_part(pv);
          next_wa = pv[LIW-1:0];
          prev_we = is_part(nx);
          prev_wa = nx[LIW-1:0];
          prev_wd = pv;
        end
      end
      cllu_pkg::WR_LINK: begin
        prev_we = run && is_part(oh_r);
        prev_wa = oh_r[LIW-1:0];
        prev_wd = p_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[rd_box];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_r <= prev_mem[in_particle[LIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_r <= next_mem[in_particle[LIW-1:0]];
  end

  // Head table sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (ctl.wr == cllu_pkg::WR_CLEAR && clr_busy_r) begin
      if (clr_cnt_r == LAST_BOX) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + BIW'(1);
      end
    end
  end

  assign dstat.clr_busy  = clr_busy_r;
  assign dstat.is_remove = (cmd_r == cllu_pkg::CMD_REMOVE);
  assign old_head        = oh_r;
  assign new_head        = nh_r;

  `CLLU_CHECK_ANY(a_reset_clears, !rst_n |=> clr_busy_r, "reset did not start the sweep")
  `CLLU_CHECK(a_sweep_once, !clr_busy_r |=> !clr_busy_r, "sweep restarted")

endmodule

// File: src/cell_list_link_update.sv
`timescale 1ns / 1ps
`include "cell_list_link_update_assert.svh"

// Channel  Ports                                              Direction
// input    in_valid in_stall in_command in_particle in_box_x in_box_y  in
// result   out_valid out_stall out_old_head out_new_head       out
//
// An add runs the accept, execute, link and emit steps, a remove skips the link step, as
// set by the single write port of the previous-link memory and the registered reads.
// After reset the whole head table is swept, with in_stall high.
// A new item is taken while the last result still waits in the output register;
// a result stalls in the emit step only while the output register is full.

module cell_list_link_update #(
  parameter int BOXES_X   = 32,
  parameter int BOXES_Y   = 32,
  parameter int PARTICLES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic [cllu_pkg::PART_W-1:0]         in_particle,
  input  logic [cllu_pkg::BOX_W-1:0]          in_box_x,
  input  logic [cllu_pkg::BOX_W-1:0]          in_box_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cllu_pkg::HEAD_W-1:0]  out_old_head,
  output logic signed [cllu_pkg::HEAD_W-1:0]  out_new_head
);

  cllu_pkg::uop_t     ctl;
  cllu_pkg::stat_t    stat;
  cllu_pkg::dp_stat_t dstat;

  logic                        in_fire, out_busy, load_out;
  logic                        out_valid_r, out_valid_nxt;
  logic [cllu_pkg::HEAD_W-1:0] old_head, new_head;
  logic [cllu_pkg::HEAD_W-1:0] old_head_r, new_head_r;

  // Handshake
  assign in_stall = !ctl.accept;
  assign in_fire  = in_valid && ctl.accept;
  assign out_busy = out_valid_r && out_stall;
  assign load_out = ctl.emit && !out_busy;

  assign stat.in_fire  = in_fire;
  assign stat.out_busy = out_busy;
  assign stat.dp       = dstat;

  cllu_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  cllu_dp #(
    .BOXES_X   (BOXES_X),
    .BOXES_Y   (BOXES_Y),
    .PARTICLES (PARTICLES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_fire     (in_fire),
    .in_command  (in_command),
    .in_particle (in_particle),
    .in_box_x    (in_box_x),
    .in_box_y    (in_box_y),
    .dstat       (dstat),
    .old_head    (old_head),
    .new_head    (new_head)
  );

  // Output register
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      old_head_r <= old_head;
      new_head_r <= new_head;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_old_head = old_head_r;
  assign out_new_head = new_head_r;

  `CLLU_CHECK(a_result_from_emit, $rose(out_valid_r) |-> $past(ctl.emit), "result without emit step")

endmodule

// File: verif/cell_list_link_update_test.sv
`timescale 1ns / 1ps

module cell_list_link_update_test;

  localparam int BOXES_X = 32;
  localparam int BOXES_Y = 32;
  localparam int NBOXES  = BOXES_X * BOXES_Y;
  localparam int SPAN    = cllu_pkg::PART_SPAN;

  typedef logic signed [cllu_pkg::HEAD_W-1:0] head_t;
  typedef logic [cllu_pkg::PART_W-1:0]        part_t;
  typedef logic [cllu_pkg::BOX_W-1:0]         boxc_t;

  typedef struct {
    head_t old_head;
    head_t new_head;
  } head_pair_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid;
  logic  in_stall;
  logic  in_command;
  part_t in_particle;
  boxc_t in_box_x;
  boxc_t in_box_y;
  logic  out_valid;
  logic  out_stall = 1'b0;
  head_t out_old_head;
  head_t out_new_head;

  // Predicted list state
  head_t head_tab [NBOXES];
  head_t prev_ln [SPAN];
  head_t next_ln [SPAN];

  head_pair_t pending_heads [$];
  int err_count = 0;

  // Stimulus bookkeeping: which particles were ever added, which are listed and where
  bit    ever_added [SPAN];
  bit    listed [SPAN];
  boxc_t lx [SPAN];
  boxc_t ly [SPAN];

  // Idle controls
  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  cell_list_link_update #(
    .BOXES_X(BOXES_X),
    .BOXES_Y(BOXES_Y),
    .PARTICLES(SPAN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_particle(in_particle),
    .in_box_x(in_box_x),
    .in_box_y(in_box_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_old_head(out_old_head),
    .out_new_head(out_new_head)
  );

  always #1 clk = ~clk;

  // Apply one command to the predicted lists, return the box head before and after
  function automatic void update_lists(input cllu_pkg::cmd_t cmd, input part_t part,
                                       input boxc_t bx, input boxc_t by,
                                       output head_t old_h, output head_t new_h);
    int    box;
    head_t p;
    head_t nxt;
    head_t prv;
    box = int'(by) * BOXES_X + int'(bx);
    p = head_t'({1'b0, part});
    old_h = head_tab[box];
    if (cmd == cllu_pkg::CMD_ADD) begin
      head_tab[box] = p;
      prev_ln[part] = cllu_pkg::NONE;
      next_ln[part] = old_h;
      if (old_h != cllu_pkg::NONE) prev_ln[old_h[cllu_pkg::PART_W-1:0]] = p;
    end else begin
      nxt = next_ln[part];
      if (old_h == p) begin
        // removing the head: its successor takes over
        head_tab[box] = nxt;
        if (nxt != cllu_pkg::NONE) prev_ln[nxt[cllu_pkg::PART_W-1:0]] = cllu_pkg::NONE;
      end else begin
        // join neighbors; a missing neighbor gets no write
        prv = prev_ln[part];
        if (prv != cllu_pkg::NONE) next_ln[prv[cllu_pkg::PART_W-1:0]] = nxt;
        if (nxt != cllu_pkg::NONE) prev_ln[nxt[cllu_pkg::PART_W-1:0]] = prv;
      end
    end
    new_h = head_tab[box];
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Offer one item, wait for it to be taken, then queue its expected heads
  task automatic send_item(input cllu_pkg::cmd_t cmd, input part_t part,
                           input boxc_t bx, input boxc_t by);
    head_pair_t want;
    while (in_gaps && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_particle <= part;
    in_box_x    <= bx;
    in_box_y    <= by;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_lists(cmd, part, bx, by, want.old_head, want.new_head);
    pending_heads.push_back(want);
    if (cmd == cllu_pkg::CMD_ADD) begin
      ever_added[part] = 1'b1;
      listed[part] = 1'b1;
      lx[part] = bx;
      ly[part] = by;
    end else begin
      listed[part] = 1'b0;
    end
  endtask

  // Mostly well-formed traffic: add unlisted particles, remove listed ones from their box.
  // A few percent re-add a listed particle or remove one naming an arbitrary box.
  task automatic random_op(input int pool_top, input int box_top);
    int             p;
    cllu_pkg::cmd_t cmd;
    boxc_t          bx;
    boxc_t          by;
    p = $urandom_range(pool_top);
    bx = cllu_pkg::BOX_W'($urandom_range(box_top));
    by = cllu_pkg::BOX_W'($urandom_range(box_top));
    if (ever_added[p] && $urandom_range(99) < 6) begin
      cmd = $urandom_range(1) ? cllu_pkg::CMD_REMOVE : cllu_pkg::CMD_ADD;
    end else if (listed[p]) begin
      cmd = cllu_pkg::CMD_REMOVE;
      bx = lx[p];
      by = ly[p];
    end else begin
      cmd = cllu_pkg::CMD_ADD;
    end
    send_item(cmd, cllu_pkg::PART_W'(p), bx, by);
  endtask

  // Head, middle and tail removal, field extremes
  task automatic test_list_basics();
    send_item(cllu_pkg::CMD_ADD, 10'd0, 5'd0, 5'd0);
    send_item(cllu_pkg::CMD_ADD, 10'd1023, 5'd31, 5'd31);
    send_item(cllu_pkg::CMD_ADD, 10'd5, 5'd0, 5'd0);
    send_item(cllu_pkg::CMD_REMOVE, 10'd5, 5'd0, 5'd0);
    send_item(cllu_pkg::CMD_ADD, 10'd7, 5'd0, 5'd0);
    send_item(cllu_pkg::CMD_ADD, 10'd8, 5'd0, 5'd0);
    send_item(cllu_pkg::CMD_REMOVE, 10'd7, 5'd0, 5'd0);
    send_item(cllu_pkg::CMD_REMOVE, 10'd0, 5'd0, 5'd0);
    send_item(cllu_pkg::CMD_REMOVE, 10'd8, 5'd0, 5'd0);
    send_item(cllu_pkg::CMD_ADD, 10'd682, 5'd21, 5'd10);
    send_item(cllu_pkg::CMD_ADD, 10'd341, 5'd10, 5'd21);
    send_item(cllu_pkg::CMD_REMOVE, 10'd1023, 5'd31, 5'd31);
    send_item(cllu_pkg::CMD_REMOVE, 10'd682, 5'd21, 5'd10);
  endtask

  // Re-add of a listed particle, remove naming the wrong box, link write through empty
  task automatic test_odd_commands();
    send_item(cllu_pkg::CMD_ADD, 10'd100, 5'd7, 5'd3);
    send_item(cllu_pkg::CMD_ADD, 10'd100, 5'd7, 5'd3);
    send_item(cllu_pkg::CMD_REMOVE, 10'd100, 5'd7, 5'd3);
    send_item(cllu_pkg::CMD_ADD, 10'd101, 5'd8, 5'd3);
    send_item(cllu_pkg::CMD_ADD, 10'd102, 5'd8, 5'd3);
    send_item(cllu_pkg::CMD_REMOVE, 10'd101, 5'd9, 5'd3);
    send_item(cllu_pkg::CMD_ADD, 10'd103, 5'd12, 5'd3);
    send_item(cllu_pkg::CMD_ADD, 10'd104, 5'd12, 5'd3);
    // 104 is a head with no previous link; naming another box skips that write
    send_item(cllu_pkg::CMD_REMOVE, 10'd104, 5'd13, 5'd3);
  endtask

  // Mostly a few crowded boxes so lists grow long, sometimes the whole grid
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) random_op(47, 1);
      else random_op(SPAN - 1, BOXES_X - 1);
    end
  endtask

  // Back to back items with no idling on either side
  task automatic test_full_rate();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    test_random_mix(150);
    in_gaps = 1'b1;
    out_gaps = 1'b1;
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_output_hold();
    hold_req = 1'b1;
    test_random_mix(150);
  endtask

  // Receiver stall; the long hold is counted here
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (out_gaps) begin
      out_stall <= ($urandom_range(99) < 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : check_heads
    head_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_heads.size() == 0) begin
        flag_mismatch($sformatf("unexpected result old %0d new %0d",
                                out_old_head, out_new_head));
      end else begin
        want = pending_heads.pop_front();
        if (out_old_head !== want.old_head)
          flag_mismatch($sformatf("old_head got %0d want %0d", out_old_head, want.old_head));
        if (out_new_head !== want.new_head)
          flag_mismatch($sformatf("new_head got %0d want %0d", out_new_head, want.new_head));
      end
    end
  end

  initial begin
    in_valid    <= 1'b0;
    in_command  <= cllu_pkg::CMD_ADD;
    in_particle <= '0;
    in_box_x    <= '0;
    in_box_y    <= '0;
    for (int i = 0; i < NBOXES; i++) head_tab[i] = cllu_pkg::NONE;
    for (int i = 0; i < SPAN; i++) begin
      prev_ln[i] = cllu_pkg::NONE;
      next_ln[i] = cllu_pkg::NONE;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_list_basics();
    test_odd_commands();
    test_random_mix(550);
    test_full_rate();
    test_output_hold();
    in_valid <= 1'b0;

    // drain, then wait for anything stray
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/cllu_pkg.sv
src/cllu_seq.sv
src/cllu_dp.sv
src/cell_list_link_update.sv
verif/cell_list_link_update_test.sv
